// ===== hdl/lrfbs_pkg.sv =====
// Shared types and constants for the LCD rectangle fill byte streamer.
// No dependencies; every module of the block imports this package.
package lrfbs_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 160;
    localparam int PANEL_HEIGHT = 80;

    // Controller command bytes and fixed data bytes
    localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h2A;
    localparam logic [7:0] CMD_ROW_WINDOW    = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE  = 8'h2C;
    localparam logic [7:0] DATA_ZERO         = 8'h00;

    // Operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_COLUMN_OFFSET = 1'b0;
    localparam logic CFG_ROW_OFFSET    = 1'b1;

    // Header step codes
    localparam logic [3:0] STEP_COL_CMD    = 4'd0;
    localparam logic [3:0] STEP_COL_START  = 4'd2;
    localparam logic [3:0] STEP_COL_END    = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD    = 4'd5;
    localparam logic [3:0] STEP_ROW_START  = 4'd7;
    localparam logic [3:0] STEP_ROW_END    = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD    = 4'd10;
    localparam logic [3:0] STEP_PIXELS     = 4'd11;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic        operation;
        logic [7:0]  rect_x;
        logic [7:0]  rect_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [15:0] fill_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        rect_ok;
        logic [7:0]  col_start;
        logic [7:0]  col_end;
        logic [7:0]  row_start;
        logic [7:0]  row_end;
        logic [15:0] colour;
        logic [7:0]  width;
        logic [7:0]  height;
    } q_entry_t;

    // Status of the back part, for checking
    typedef struct packed {
        logic       busy;
        logic [3:0] header_step;
    } back_status_t;

endpackage

// ===== hdl/lrfbs_front.sv =====
// Front part: holds the offset registers, clips start requests to the panel
// and turns each accepted item into a queue entry. Depends on lrfbs_pkg.
module lrfbs_front
    import lrfbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  in_item_t   item,
    output q_entry_t   entry
);

    localparam logic [8:0] PANEL_W9 = 9'(PANEL_WIDTH);
    localparam logic [8:0] PANEL_H9 = 9'(PANEL_HEIGHT);

    logic [7:0] col_offset_reg;
    logic [7:0] row_offset_reg;

    logic [8:0] x_end;
    logic [8:0] y_end;
    logic [7:0] clip_w;
    logic [7:0] clip_h;
    logic       on_panel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_offset_reg <= 8'd0;
            row_offset_reg <= 8'd24;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_COLUMN_OFFSET: col_offset_reg <= cfg_data;
                CFG_ROW_OFFSET:    row_offset_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        x_end    = {1'b0, item.rect_x} + {1'b0, item.rect_width};
        y_end    = {1'b0, item.rect_y} + {1'b0, item.rect_height};
        on_panel = ({1'b0, item.rect_x} < PANEL_W9) && ({1'b0, item.rect_y} < PANEL_H9);
        // Trim the size so the rectangle stops at the panel edge
        clip_w   = (x_end > PANEL_W9) ? 8'(PANEL_W9 - {1'b0, item.rect_x}) : item.rect_width;
        clip_h   = (y_end > PANEL_H9) ? 8'(PANEL_H9 - {1'b0, item.rect_y}) : item.rect_height;

        entry.is_start  = (item.operation == OP_START);
        entry.rect_ok   = on_panel && (clip_w != 8'd0) && (clip_h != 8'd0);
        entry.col_start = item.rect_x + col_offset_reg;
        entry.col_end   = item.rect_x + clip_w - 8'd1 + col_offset_reg;
        entry.row_start = item.rect_y + row_offset_reg;
        entry.row_end   = item.rect_y + clip_h - 8'd1 + row_offset_reg;
        entry.colour    = item.fill_value;
        entry.width     = clip_w;
        entry.height    = clip_h;
    end

endmodule

// ===== hdl/lrfbs_queue.sv =====
// Short command queue between the front and back parts.
// Depends on lrfbs_pkg for the entry type and depth.
module lrfbs_queue
    import lrfbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  q_entry_t          push_data,
    input  logic              pop,
    output q_entry_t          head,
    output logic              not_empty,
    output logic              full,
    output logic [QCNT_W-1:0] count
);

    q_entry_t            mem [QDEPTH];
    logic [QADDR_W-1:0]  wr_ptr_reg;
    logic [QADDR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/lrfbs_back.sv =====
// Back part: holds the fill state, walks the header and pixel bytes and
// drives the output register. Depends on lrfbs_pkg.
module lrfbs_back
    import lrfbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_entry_t     head,
    input  logic         not_empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output out_item_t    out_item,
    output back_status_t status
);

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  col_start_reg, col_start_next;
    logic [7:0]  col_end_reg, col_end_next;
    logic [7:0]  row_start_reg, row_start_next;
    logic [7:0]  row_end_reg, row_end_next;
    logic [15:0] colour_reg, colour_next;
    logic [7:0]  width_reg, width_next;
    logic [7:0]  px_left_reg, px_left_next;
    logic [7:0]  rows_left_reg, rows_left_next;
    logic        low_half_reg, low_half_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic        can_load;
    logic        fin;

    assign can_load = !out_valid_reg || !out_stall;
    assign pop      = not_empty && can_load;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign status.busy        = busy_reg;
    assign status.header_step = step_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        colour_next    = colour_reg;
        width_next     = width_reg;
        px_left_next   = px_left_reg;
        rows_left_next = rows_left_reg;
        low_half_next  = low_half_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        fin            = 1'b0;

        if (pop)
        begin
            if (head.is_start)
            begin
                // Drop starts while busy, with the corner off the panel, or when clipping leaves nothing
                if (!busy_reg && head.rect_ok)
                begin
                    busy_next      = 1'b1;
                    step_next      = STEP_COL_CMD;
                    col_start_next = head.col_start;
                    col_end_next   = head.col_end;
                    row_start_next = head.row_start;
                    row_end_next   = head.row_end;
                    colour_next    = head.colour;
                    width_next     = head.width;
                    px_left_next   = head.width;
                    rows_left_next = head.height;
                    low_half_next  = 1'b0;
                end
            end
            else if (busy_reg)
            begin
                out_valid_next = 1'b1;
                out_item_next.last = 1'b0;
                if (step_reg < STEP_PIXELS)
                begin
                    case (step_reg)
                        STEP_COL_CMD:
                        begin
                            out_item_next.out_byte = CMD_COLUMN_WINDOW;
                            out_item_next.is_data  = 1'b0;
                        end
                        STEP_COL_START:
                        begin
                            out_item_next.out_byte = col_start_reg;
                            out_item_next.is_data  = 1'b1;
                        end
                        STEP_COL_END:
                        begin
                            out_item_next.out_byte = col_end_reg;
                            out_item_next.is_data  = 1'b1;
                        end
                        STEP_ROW_CMD:
                        begin
                            out_item_next.out_byte = CMD_ROW_WINDOW;
                            out_item_next.is_data  = 1'b0;
                        end
                        STEP_ROW_START:
                        begin
                            out_item_next.out_byte = row_start_reg;
                            out_item_next.is_data  = 1'b1;
                        end
                        STEP_ROW_END:
                        begin
                            out_item_next.out_byte = row_end_reg;
                            out_item_next.is_data  = 1'b1;
                        end
                        STEP_MEM_CMD:
                        begin
                            out_item_next.out_byte = CMD_MEMORY_WRITE;
                            out_item_next.is_data  = 1'b0;
                        end
                        default:
                        begin
                            out_item_next.out_byte = DATA_ZERO;
                            out_item_next.is_data  = 1'b1;
                        end
                    endcase
                    step_next = step_reg + 4'd1;
                end
                else if (!low_half_reg)
                begin
                    out_item_next.out_byte = colour_reg[15:8];
                    out_item_next.is_data  = 1'b1;
                    low_half_next          = 1'b1;
                end
                else
                begin
                    fin = (px_left_reg <= 8'd1) && (rows_left_reg <= 8'd1);
                    out_item_next.out_byte = colour_reg[7:0];
                    out_item_next.is_data  = 1'b1;
                    out_item_next.last     = fin;
                    low_half_next          = 1'b0;
                    if (fin)
                    begin
                        busy_next      = 1'b0;
                        step_next      = STEP_COL_CMD;
                        px_left_next   = 8'd0;
                        rows_left_next = 8'd0;
                    end
                    else if (px_left_reg <= 8'd1)
                    begin
                        px_left_next   = width_reg;
                        rows_left_next = rows_left_reg - 8'd1;
                    end
                    else
                    begin
                        px_left_next = px_left_reg - 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COL_CMD;
            px_left_reg   <= 8'd0;
            rows_left_reg <= 8'd0;
            low_half_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            px_left_reg   <= px_left_next;
            rows_left_reg <= rows_left_next;
            low_half_reg  <= low_half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_start_reg <= col_start_next;
        col_end_reg   <= col_end_next;
        row_start_reg <= row_start_next;
        row_end_reg   <= row_end_next;
        colour_reg    <= colour_next;
        width_reg     <= width_next;
        out_item_reg  <= out_item_next;
    end

endmodule

// ===== hdl/lcd_rect_fill_byte_streamer_top.sv =====
// LCD rectangle fill byte streamer, top level. Depends on lrfbs_pkg and the
// front, queue and back modules.
// An accepted item is written into the queue, then popped by the back part,
// which registers its byte in the output register.
// Throughput: one item per cycle while out_stall does not hold the output register.
// Reset (rst_n low, asynchronous): idle, queue empty, offsets 0 and 24.
module lcd_rect_fill_byte_streamer_top
    import lrfbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    // Classified entry from the front part
    q_entry_t            front_entry;
    q_entry_t            q_head;
    logic                q_push;
    logic                q_pop;
    logic                q_not_empty;
    logic                q_full;
    logic [QCNT_W-1:0]   q_count;
    back_status_t        back_status;

    // Hold off the source only when the queue has no free slot
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    lrfbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_item),
        .entry     (front_entry)
    );

    // Decouple classification from byte generation
    lrfbs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_entry),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full),
        .count     (q_count)
    );

    // Back part advances the fill and owns the output register
    lrfbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .status    (back_status)
    );

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("command queue count beyond depth");

    // Never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_count != '0)
        else $error("pop from empty command queue");

    // Header step stays within the header and pixel phases
    assert property (@(posedge clk) disable iff (!rst_n)
        back_status.header_step <= STEP_PIXELS)
        else $error("header step out of range");

    // A final byte leaves the back part idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && back_status.busy && !q_head.is_start &&
        back_status.header_step == STEP_PIXELS |=>
        !(out_valid && out_item.last) || !back_status.busy)
        else $error("still busy after final byte");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lcd_rect_fill_byte_streamer_top: directed table, then random
// fill streams. Depends on lrfbs_pkg and the block RTL; expected bytes come from an in-house model.
module testbench;
    import lrfbs_pkg::*;

    localparam int   CLK_HALF      = 4;
    localparam int   LIMIT_CYCLES  = 1_000_000;
    localparam int   PHASE_ITEMS   = 420;
    localparam int   SETTLE_CYCLES = 10;
    localparam logic FLAG_CMD      = 1'b0;
    localparam logic FLAG_DATA     = 1'b1;

    // How a directed row is checked: no byte at all, a byte typed into the table,
    // or whatever the fill model predicts.
    typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_PREDICT} chk_kind_t;

    typedef struct packed {
        chk_kind_t kind;
        in_item_t  item;
        out_item_t want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;

    lcd_rect_fill_byte_streamer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Fill model state: offsets as last written, window and pixel counters of the
    // fill in progress.
    logic [7:0]  col_ofs;
    logic [7:0]  row_ofs;
    bit          fill_busy;
    logic [3:0]  hdr_step;
    logic [7:0]  col_lo;
    logic [7:0]  col_hi;
    logic [7:0]  row_lo;
    logic [7:0]  row_hi;
    logic [15:0] fill_colour;
    logic [7:0]  span_w;
    logic [7:0]  px_left;
    logic [7:0]  rows_left;
    bit          low_next;

    out_item_t   bytes_due[$];   // bytes predicted but not yet seen on the output
    int          errors = 0;
    int          items_done = 0; // items that started a fill or produced a byte
    int          burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("testbench failed");
        $finish;
    end

    function automatic out_item_t make_byte(logic [7:0] val, logic flag, logic fin);
        out_item_t b;
        b.out_byte = val;
        b.is_data  = flag;
        b.last     = fin;
        return b;
    endfunction

    function automatic in_item_t make_item(logic op, logic [7:0] x, logic [7:0] y,
                                           logic [7:0] w, logic [7:0] h, logic [15:0] colour);
        in_item_t it;
        it.operation   = op;
        it.rect_x      = x;
        it.rect_y      = y;
        it.rect_width  = w;
        it.rect_height = h;
        it.fill_value  = colour;
        return it;
    endfunction

    function automatic dir_row_t row(chk_kind_t kind, in_item_t it, out_item_t want);
        dir_row_t r;
        r.kind = kind;
        r.item = it;
        r.want = want;
        return r;
    endfunction

    // Apply one accepted item to the fill model; got is set when it yields a byte.
    task automatic fill_step(input in_item_t it, output bit got, output out_item_t b);
        int x;
        int y;
        int w;
        int h;
        bit fin;
        got = 1'b0;
        b   = '0;
        x   = int'(it.rect_x);
        y   = int'(it.rect_y);
        w   = int'(it.rect_width);
        h   = int'(it.rect_height);
        if (it.operation == OP_START)
        begin
            // Ignore while busy or when the corner is off the panel; clip, then
            // drop an empty rectangle.
            if (!fill_busy && x < PANEL_WIDTH && y < PANEL_HEIGHT)
            begin
                if (x + w > PANEL_WIDTH)
                    w = PANEL_WIDTH - x;
                if (y + h > PANEL_HEIGHT)
                    h = PANEL_HEIGHT - y;
                if (w != 0 && h != 0)
                begin
                    col_lo      = 8'(x + col_ofs);
                    col_hi      = 8'(x + w - 1 + col_ofs);
                    row_lo      = 8'(y + row_ofs);
                    row_hi      = 8'(y + h - 1 + row_ofs);
                    fill_colour = it.fill_value;
                    span_w      = 8'(w);
                    px_left     = 8'(w);
                    rows_left   = 8'(h);
                    low_next    = 1'b0;
                    hdr_step    = STEP_COL_CMD;
                    fill_busy   = 1'b1;
                end
            end
        end
        else if (fill_busy)
        begin
            got = 1'b1;
            if (hdr_step < STEP_PIXELS)
            begin
                case (hdr_step)
                    STEP_COL_CMD:   b = make_byte(CMD_COLUMN_WINDOW, FLAG_CMD, 1'b0);
                    STEP_COL_START: b = make_byte(col_lo, FLAG_DATA, 1'b0);
                    STEP_COL_END:   b = make_byte(col_hi, FLAG_DATA, 1'b0);
                    STEP_ROW_CMD:   b = make_byte(CMD_ROW_WINDOW, FLAG_CMD, 1'b0);
                    STEP_ROW_START: b = make_byte(row_lo, FLAG_DATA, 1'b0);
                    STEP_ROW_END:   b = make_byte(row_hi, FLAG_DATA, 1'b0);
                    STEP_MEM_CMD:   b = make_byte(CMD_MEMORY_WRITE, FLAG_CMD, 1'b0);
                    default:        b = make_byte(DATA_ZERO, FLAG_DATA, 1'b0);
                endcase
                hdr_step = hdr_step + 4'd1;
            end
            else if (!low_next)
            begin
                b        = make_byte(fill_colour[15:8], FLAG_DATA, 1'b0);
                low_next = 1'b1;
            end
            else
            begin
                fin      = (px_left <= 8'd1) && (rows_left <= 8'd1);
                b        = make_byte(fill_colour[7:0], FLAG_DATA, fin);
                low_next = 1'b0;
                if (fin)
                begin
                    fill_busy = 1'b0;
                    hdr_step  = STEP_COL_CMD;
                    px_left   = 8'd0;
                    rows_left = 8'd0;
                end
                else if (px_left <= 8'd1)
                begin
                    px_left   = span_w;
                    rows_left = rows_left - 8'd1;
                end
                else
                begin
                    px_left = px_left - 8'd1;
                end
            end
        end
    endtask

    // Offer one item, hold it until accepted, then record what it should produce.
    // The sender works in bursts; a gap precedes each burst.
    task automatic send_item(input in_item_t it, input chk_kind_t kind, input out_item_t want);
        int        gap;
        bit        got;
        bit        was_busy;
        out_item_t b;
        if (burst_left == 0)
        begin
            // Now and then a long stretch with no idling at all.
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        was_busy = fill_busy;
        fill_step(it, got, b);
        if (kind == CHK_TYPED)
            bytes_due.push_back(want);
        else if (kind == CHK_PREDICT && got)
            bytes_due.push_back(b);
        if (got || (!was_busy && fill_busy))
            items_done++;
    endtask

    // Start request: mostly small rectangles on the panel, some clipped at the
    // edges, a few full-width strips or full-height columns, some off-panel.
    function automatic in_item_t pick_start();
        in_item_t it;
        int       r;
        it.operation  = OP_START;
        it.fill_value = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            it.rect_x      = 8'($urandom_range(0, PANEL_WIDTH - 1));
            it.rect_y      = 8'($urandom_range(0, PANEL_HEIGHT - 1));
            it.rect_width  = 8'($urandom_range(0, 6));
            it.rect_height = 8'($urandom_range(0, 3));
        end
        else if (r < 85)
        begin
            it.rect_x      = 8'($urandom_range(PANEL_WIDTH - 20, PANEL_WIDTH - 1));
            it.rect_y      = 8'($urandom_range(PANEL_HEIGHT - 10, PANEL_HEIGHT - 1));
            it.rect_width  = 8'($urandom);
            it.rect_height = 8'($urandom);
        end
        else if (r < 88)
        begin
            it.rect_x      = 8'($urandom);
            it.rect_y      = 8'($urandom);
            it.rect_width  = 8'($urandom);
            it.rect_height = 8'($urandom);
        end
        else if (r < 94)
        begin
            it.rect_x      = 8'($urandom_range(0, 3));
            it.rect_y      = 8'($urandom_range(0, PANEL_HEIGHT - 1));
            it.rect_width  = 8'($urandom_range(200, 255));
            it.rect_height = 8'($urandom_range(1, 2));
        end
        else if (r < 97)
        begin
            it.rect_x      = 8'($urandom_range(0, PANEL_WIDTH - 1));
            it.rect_y      = 8'($urandom_range(0, 3));
            it.rect_width  = 8'd1;
            it.rect_height = 8'($urandom_range(200, 255));
        end
        else
        begin
            it.rect_x      = 8'($urandom_range(PANEL_WIDTH, 255));
            it.rect_y      = 8'($urandom_range(PANEL_HEIGHT, 255));
            it.rect_width  = 8'($urandom);
            it.rect_height = 8'($urandom);
            if ($urandom_range(0, 1) == 0)
                it.rect_x = 8'($urandom_range(0, PANEL_WIDTH - 1));
        end
        return it;
    endfunction

    // Any item at all; the rectangle fields of an advance are don't-care but
    // still get random content.
    function automatic in_item_t any_item(logic op);
        return make_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom));
    endfunction

    // Well-formed fills with random content: a start, then advances until the
    // last byte. Mix in starts while busy, and sometimes abandon a stream so the
    // next start lands on a busy block.
    task automatic random_phase(input int quota);
        int stop_at;
        int r;
        stop_at = items_done + quota;
        while (items_done < stop_at)
        begin
            send_item(pick_start(), CHK_PREDICT, '0);
            while (fill_busy && items_done < stop_at)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_item(any_item(1'($urandom)), CHK_PREDICT, '0);
                else if (r == 4)
                    break;
                else
                    send_item(any_item(OP_ADVANCE), CHK_PREDICT, '0);
            end
            if (!fill_busy && $urandom_range(0, 9) == 0)
                send_item(any_item(OP_ADVANCE), CHK_PREDICT, '0);
        end
    endtask

    // Drop valid, wait until every predicted byte is out, then wait further
    // for starts still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_offsets(input logic [7:0] col, input logic [7:0] rw);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COLUMN_OFFSET;
        cfg_data  <= col;
        @(posedge clk);
        cfg_index <= CFG_ROW_OFFSET;
        cfg_data  <= rw;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        col_ofs = col;
        row_ofs = rw;
    endtask

    // Receiver: stall pattern whose mode is picked at random, plus
    // long hold-offs while the sender is busy offering, to back the block up.
    initial
    begin : receiver
        int cyc;
        int mode;
        int left;
        int hold_left;
        int next_hold;
        cyc       = 0;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        next_hold = 800;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (hold_left == 0 && cyc > next_hold && in_valid && out_valid)
            begin
                hold_left = 400;
                next_hold = cyc + 5000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= cyc[0];
                endcase
            end
        end
    end

    // Compare every accepted byte with the oldest prediction.
    always @(posedge clk)
    begin : check_bytes
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %h/%b/%b", $time,
                         out_item.out_byte, out_item.is_data, out_item.last);
                errors++;
            end
            else
            begin
                want = bytes_due.pop_front();
                if (out_item.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h", $time,
                             want.out_byte, out_item.out_byte);
                    errors++;
                end
                if (out_item.is_data !== want.is_data)
                begin
                    $display("%0t: is_data mismatch: expected %b, actual %b", $time,
                             want.is_data, out_item.is_data);
                    errors++;
                end
                if (out_item.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b", $time,
                             want.last, out_item.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t  rows[$];
        out_item_t none;
        none = '0;

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_COLUMN_OFFSET;
        cfg_data  <= 8'd0;
        in_valid  <= 1'b0;
        in_item   <= '0;

        // Model comes out of reset with the same offsets as the block.
        col_ofs     = 8'd0;
        row_ofs     = 8'd24;
        fill_busy   = 1'b0;
        hdr_step    = STEP_COL_CMD;
        col_lo      = 8'd0;
        col_hi      = 8'd0;
        row_lo      = 8'd0;
        row_hi      = 8'd0;
        fill_colour = 16'd0;
        span_w      = 8'd0;
        px_left     = 8'd0;
        rows_left   = 8'd0;
        low_next    = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Advance while idle, rejected starts, then a 1x1 fill at
        // the origin whose bytes are spelled out, with a start while busy.
        rows.push_back(row(CHK_NONE, make_item(OP_ADVANCE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                               16'hFFFF), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'hFF, 8'h00, 8'd10, 8'd10,
                                               16'h1234), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'h00, 8'hFF, 8'd10, 8'd10,
                                               16'h1234), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'd0, 8'd0, 8'd0, 8'd5,
                                               16'h5555), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'd10, 8'd79, 8'd3, 8'd0,
                                               16'hAAAA), none));
        rows.push_back(row(CHK_NONE, make_item(OP_ADVANCE, 8'd0, 8'd0, 8'd0, 8'd0,
                                               16'h0000), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'd0, 8'd0, 8'd1, 8'd1,
                                               16'hFFFF), none));
        rows.push_back(row(CHK_NONE, make_item(OP_START, 8'd1, 8'd1, 8'd5, 8'd5,
                                               16'h0000), none));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE),
                           make_byte(CMD_COLUMN_WINDOW, FLAG_CMD, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(DATA_ZERO, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'd0, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(DATA_ZERO, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'd0, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE),
                           make_byte(CMD_ROW_WINDOW, FLAG_CMD, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(DATA_ZERO, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'd24, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(DATA_ZERO, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'd24, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE),
                           make_byte(CMD_MEMORY_WRITE, FLAG_CMD, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'hFF, FLAG_DATA, 1'b0)));
        rows.push_back(row(CHK_TYPED, any_item(OP_ADVANCE), make_byte(8'hFF, FLAG_DATA, 1'b1)));
        // Bottom-right corner with maximum size: clips down to one pixel. Its
        // stream is finished by the random part.
        rows.push_back(row(CHK_PREDICT, make_item(OP_START, 8'd159, 8'd79, 8'hFF, 8'hFF,
                                                  16'h8001), none));
        repeat (3)
            rows.push_back(row(CHK_PREDICT, any_item(OP_ADVANCE), none));

        foreach (rows[i])
            send_item(rows[i].item, rows[i].kind, rows[i].want);

        // Random phases, each under its own pair of offsets.
        random_phase(PHASE_ITEMS);
        settle();
        set_offsets(8'hFF, 8'hFF);
        random_phase(PHASE_ITEMS);
        settle();
        set_offsets(8'h00, 8'h00);
        random_phase(PHASE_ITEMS);
        settle();
        set_offsets(8'($urandom), 8'($urandom));
        random_phase(PHASE_ITEMS);
        settle();

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lrfbs_pkg.sv
hdl/lrfbs_front.sv
hdl/lrfbs_queue.sv
hdl/lrfbs_back.sv
hdl/lcd_rect_fill_byte_streamer_top.sv
test/testbench.sv
